// ===== hdl/ipps_pkg.sv =====
// ----------------------------------------------------------------------------
// ipps_pkg
// Shared widths, constants, register codes and pipeline control types for the
// incremental PID speed loop.
// ----------------------------------------------------------------------------
package ipps_pkg;

	localparam int SPEED_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = 17;
	localparam int DELTA_W   = 18;
	localparam int DD_W      = 19;
	localparam int SUM_W     = 38;
	localparam int MAG_W     = 10;
	localparam int QUO_W     = 4;
	localparam int STEP_W    = 5;
	localparam int WIDTH_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int RECIP_W   = 6;
	localparam int DIVP_W    = MAG_W + RECIP_W;

	localparam logic [WIDTH_W-1:0]      PERIOD_RESET    = 16'd2000;
	localparam logic [WIDTH_W-1:0]      PERIOD_MARGIN   = 16'd200;
	localparam logic [WIDTH_W-1:0]      CEIL_RESET      = PERIOD_RESET - PERIOD_MARGIN;
	localparam logic signed [ERR_W-1:0] HIGH_ERR_THRESH = 17'sd50;
	localparam logic [MAG_W-1:0]        STEP_LIMIT_HIGH = 10'd1000;
	localparam logic [MAG_W-1:0]        STEP_LIMIT_LOW  = 10'd200;

	// x/100 for x <= 1000 as (x*41) >> 12
	localparam logic [RECIP_W-1:0] RECIP_MUL   = 6'd41;
	localparam int                 RECIP_SHIFT = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP  = 2'd0,
		REG_GAIN_INT   = 2'd1,
		REG_GAIN_DERIV = 2'd2,
		REG_PWM_PERIOD = 2'd3
	} ipps_reg_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} ipps_adv_t;

endpackage

// ===== hdl/incremental_pid_pwm_speed_loop.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_pwm_speed_loop
// Velocity-form PID speed loop that steps a stored PWM width each tick.
// Input word: target_speed and measured_speed on in_valid/in_ready.
// Output word: pwm_width and width_step on out_valid/out_ready, one per input.
// Gains and PWM period are written on cfg_valid/cfg_ready (always ready) with
// cfg_index 0..3 = gain_prop, gain_int, gain_deriv, pwm_period; write only
// while no word is in flight.
// Path: an accepted word passes the input, difference, product and cap stages,
// then the width update register. Throughput: one word per cycle unless
// out_ready stalls the output; the loops are the error history subtract in
// the difference stage and the 16-bit width add and clamp in the output stage.
// The stages stall independently, so words keep entering while a result waits;
// in_ready drops only when all five stages are full and out_ready is low.
// Reset clears the error history, the width, the gains, and sets period 2000.
// ----------------------------------------------------------------------------
module incremental_pid_pwm_speed_loop (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ipps_pkg::SPEED_W-1:0]         target_speed,
	input  logic [ipps_pkg::SPEED_W-1:0]         measured_speed,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ipps_pkg::WIDTH_W-1:0]         pwm_width,
	output logic signed [ipps_pkg::STEP_W-1:0]   width_step,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ipps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ipps_pkg::GAIN_W-1:0]          cfg_data
);
	import ipps_pkg::*;

	logic [GAIN_W-1:0]          gain_prop_q;
	logic [GAIN_W-1:0]          gain_int_q;
	logic [GAIN_W-1:0]          gain_deriv_q;
	logic [WIDTH_W-1:0]         ceil_q;

	logic                       v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic                       rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_o;
	logic                       ld_s1, ld_o;
	ipps_adv_t                  adv;

	logic [SPEED_W-1:0]         tgt_s1, meas_s1;
	logic [MAG_W-1:0]           mag_s4;
	logic                       neg_s4;

	logic [WIDTH_W-1:0]         width_q;
	logic signed [STEP_W-1:0]   step_q;

	logic [DIVP_W-1:0]          divp_c;
	logic [DIVP_W-1:0]          quo_full_c;
	logic [QUO_W-1:0]           quo_c;
	logic signed [STEP_W-1:0]   step_c;
	logic signed [WIDTH_W+1:0]  wsum_c;
	logic [WIDTH_W-1:0]         wnext_c;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= '0;
			gain_int_q   <= '0;
			gain_deriv_q <= '0;
			ceil_q       <= CEIL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ipps_reg_t'(cfg_index))
				REG_GAIN_PROP:  gain_prop_q  <= cfg_data;
				REG_GAIN_INT:   gain_int_q   <= cfg_data;
				REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				REG_PWM_PERIOD: begin
					// hold the clamp ceiling, saturated at zero
					ceil_q <= (cfg_data > PERIOD_MARGIN) ? cfg_data - PERIOD_MARGIN : '0;
				end
				default: ;
			endcase
		end
	end

	// stage handshake: a stage takes a word when it is empty or its word moves on
	assign rdy_o  = !out_valid_q || out_ready;
	assign rdy_s4 = !v_s4 || rdy_o;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign in_ready  = rdy_s1;
	assign ld_s1     = in_valid && rdy_s1;
	assign adv.ld_s2 = v_s1 && rdy_s2;
	assign adv.ld_s3 = v_s2 && rdy_s3;
	assign adv.ld_s4 = v_s3 && rdy_s4;
	assign ld_o      = v_s4 && rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= ld_s1     ? 1'b1 : (adv.ld_s2 ? 1'b0 : v_s1);
			v_s2        <= adv.ld_s2 ? 1'b1 : (adv.ld_s3 ? 1'b0 : v_s2);
			v_s3        <= adv.ld_s3 ? 1'b1 : (adv.ld_s4 ? 1'b0 : v_s3);
			v_s4        <= adv.ld_s4 ? 1'b1 : (ld_o      ? 1'b0 : v_s4);
			out_valid_q <= ld_o      ? 1'b1 : ((out_valid_q && out_ready) ? 1'b0 : out_valid_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			tgt_s1  <= target_speed;
			meas_s1 <= measured_speed;
		end
	end

	ipps_law u_law (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.tgt_s1     (tgt_s1),
		.meas_s1    (meas_s1),
		.gain_prop  (gain_prop_q),
		.gain_int   (gain_int_q),
		.gain_deriv (gain_deriv_q),
		.mag_s4     (mag_s4),
		.neg_s4     (neg_s4)
	);

	// divide the capped magnitude by 100, sign it, step and clamp the width
	always_comb begin
		divp_c     = {{RECIP_W{1'b0}}, mag_s4} * {{MAG_W{1'b0}}, RECIP_MUL};
		quo_full_c = divp_c >> RECIP_SHIFT;
		quo_c      = quo_full_c[QUO_W-1:0];
		step_c     = neg_s4 ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
		wsum_c     = $signed({2'b00, width_q}) + (WIDTH_W+2)'(step_c);
		if (wsum_c[WIDTH_W+1]) begin
			wnext_c = '0;
		end else if (wsum_c[WIDTH_W:0] >= {1'b0, ceil_q}) begin
			wnext_c = ceil_q;
		end else begin
			wnext_c = wsum_c[WIDTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
		end else if (ld_o) begin
			width_q <= wnext_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_o) begin
			step_q <= step_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign pwm_width  = width_q;
	assign width_step = step_q;

`ifndef NO_ASSERTIONS
	a_width_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pwm_width <= ceil_q))
		else $error("pwm_width above clamp ceiling");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (width_step >= -5'sd10 && width_step <= 5'sd10))
		else $error("width_step outside -10..10");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_valid_q && !out_ready))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== hdl/ipps_law.sv =====
// ----------------------------------------------------------------------------
// ipps_law
// Control law stages: error differences, gain products, then the summed
// correction capped to the step limit.
// ----------------------------------------------------------------------------
module ipps_law (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ipps_pkg::ipps_adv_t                  adv,
	input  logic [ipps_pkg::SPEED_W-1:0]         tgt_s1,
	input  logic [ipps_pkg::SPEED_W-1:0]         meas_s1,
	input  logic [ipps_pkg::GAIN_W-1:0]          gain_prop,
	input  logic [ipps_pkg::GAIN_W-1:0]          gain_int,
	input  logic [ipps_pkg::GAIN_W-1:0]          gain_deriv,
	output logic [ipps_pkg::MAG_W-1:0]           mag_s4,
	output logic                                 neg_s4
);
	import ipps_pkg::*;

	localparam int PROD_P_W = GAIN_W + 1 + DELTA_W;
	localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
	localparam int PROD_D_W = GAIN_W + 1 + DD_W;

	logic signed [ERR_W-1:0]    err_q;
	logic signed [DELTA_W-1:0]  delta_q;

	logic signed [ERR_W-1:0]    e_c;
	logic signed [DELTA_W-1:0]  d_c;
	logic signed [DD_W-1:0]     dd_c;

	logic signed [ERR_W-1:0]    e_s2;
	logic signed [DELTA_W-1:0]  d_s2;
	logic signed [DD_W-1:0]     dd_s2;

	logic signed [PROD_P_W-1:0] prod_p_s3;
	logic signed [PROD_I_W-1:0] prod_i_s3;
	logic signed [PROD_D_W-1:0] prod_d_s3;
	logic                       hi_err_s3;

	logic signed [SUM_W-1:0]    sum_c;
	logic signed [SUM_W-1:0]    abs_c;
	logic [MAG_W-1:0]           limit_c;
	logic [MAG_W-1:0]           capped_c;

	// differences against the previous tick
	always_comb begin
		e_c  = $signed({1'b0, tgt_s1}) - $signed({1'b0, meas_s1});
		d_c  = DELTA_W'(e_c) - DELTA_W'(err_q);
		dd_c = DD_W'(d_c) - DD_W'(delta_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= '0;
			delta_q <= '0;
		end else if (adv.ld_s2) begin
			err_q   <= e_c;
			delta_q <= d_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			e_s2  <= e_c;
			d_s2  <= d_c;
			dd_s2 <= dd_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			prod_p_s3 <= $signed({1'b0, gain_prop}) * d_s2;
			prod_i_s3 <= $signed({1'b0, gain_int}) * e_s2;
			prod_d_s3 <= $signed({1'b0, gain_deriv}) * dd_s2;
			hi_err_s3 <= (e_s2 > HIGH_ERR_THRESH);
		end
	end

	// sum, magnitude and cap to the step limit
	always_comb begin
		sum_c   = SUM_W'(prod_p_s3) + SUM_W'(prod_i_s3) + SUM_W'(prod_d_s3);
		abs_c   = sum_c[SUM_W-1] ? -sum_c : sum_c;
		limit_c = hi_err_s3 ? STEP_LIMIT_HIGH : STEP_LIMIT_LOW;
		if (abs_c > $signed({{(SUM_W-MAG_W){1'b0}}, limit_c})) begin
			capped_c = limit_c;
		end else begin
			capped_c = abs_c[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s4) begin
			mag_s4 <= capped_c;
			neg_s4 <= sum_c[SUM_W-1];
		end
	end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the incremental PID speed loop. A directed table
// covers reset state, gain and speed extremes, the error threshold, floor and
// ceiling clamps and tiny periods. Random phases then follow, each with new
// gains and period and one of four idle patterns on the input and output channels.
// Every accepted input word is run through an in-bench model of the loop.
// Every output word is compared against the oldest expected word.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipps_pkg::*;

	localparam int     STEP_DIV      = 100;
	localparam int     STALL_LIMIT   = 1000;
	localparam int     DRAIN_CYCLES  = 16;
	localparam int     N_PHASES      = 10;
	localparam int     TICKS_PER_PH  = 90;
	localparam int     PLAN_N        = 36;

	typedef struct packed {
		logic [WIDTH_W-1:0]       width;
		logic signed [STEP_W-1:0] step;
	} tick_result_t;

	typedef enum logic [1:0] {
		ROW_TICK,
		ROW_KNOWN,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		ipps_reg_t          sel;
		logic [SPEED_W-1:0] a;
		logic [SPEED_W-1:0] b;
		tick_result_t       want;
	} plan_row_t;

	logic                        clk            = 1'b0;
	logic                        arst_n         = 1'b0;
	logic                        in_valid       = 1'b0;
	logic                        in_ready;
	logic [SPEED_W-1:0]          target_speed   = '0;
	logic [SPEED_W-1:0]          measured_speed = '0;
	logic                        out_valid;
	logic                        out_ready      = 1'b0;
	logic [WIDTH_W-1:0]          pwm_width;
	logic signed [STEP_W-1:0]    width_step;
	logic                        cfg_valid      = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index      = REG_GAIN_PROP;
	logic [GAIN_W-1:0]           cfg_data       = '0;

	// model copy of the loop state and registers
	logic [GAIN_W-1:0]  gain_p;
	logic [GAIN_W-1:0]  gain_i;
	logic [GAIN_W-1:0]  gain_d;
	logic [WIDTH_W-1:0] period_reg;
	longint             err_hist;
	longint             delta_hist;
	logic [WIDTH_W-1:0] width_hist;

	tick_result_t expected_q [$];
	tick_result_t oldest_r;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int n_errors      = 0;
	int n_ticks       = 0;
	int n_words       = 0;
	int n_cfg         = 0;
	int n_ceil_hits   = 0;
	int stall_cnt     = 0;

	plan_row_t plan [0:PLAN_N-1] = '{
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd0,     16'd0,     '{16'd0,  5'sd0}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd65535, 16'd0,     '{16'd0,  5'sd0}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_GAIN_INT,   16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd1000,  16'd0,     '{16'd10, 5'sd10}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd0,     16'd30,    '{16'd8,  -5'sd2}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd30,    16'd0,     '{16'd10, 5'sd2}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd8,  -5'sd2}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  5'sd0}},
		// floor clamp: width already at zero
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  -5'sd2}},
		// zero sum: matched speeds with only the integral gain set
		'{ROW_TICK,  REG_GAIN_PROP,  16'd500,   16'd500,   '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_PWM_PERIOD, 16'd0,     16'd201,   '{16'd0,  5'sd0}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd1000,  16'd0,     '{16'd1,  5'sd10}},
		// period at or below the margin pins the width at zero
		'{ROW_REG,   REG_PWM_PERIOD, 16'd0,     16'd200,   '{16'd0,  5'sd0}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd1000,  16'd0,     '{16'd0,  5'sd10}},
		'{ROW_REG,   REG_PWM_PERIOD, 16'd0,     16'd0,     '{16'd0,  5'sd0}},
		'{ROW_KNOWN, REG_GAIN_PROP,  16'd65535, 16'd0,     '{16'd0,  5'sd10}},
		'{ROW_REG,   REG_GAIN_INT,   16'd0,     16'd0,     '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_PWM_PERIOD, 16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd65535, 16'd0,     '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd65535, 16'd0,     '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_GAIN_PROP,  16'd0,     16'd1,     '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_GAIN_DERIV, 16'd0,     16'd65535, '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd60,    16'd0,     '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd0,     16'd60,    '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd65535, 16'd65535, '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_GAIN_DERIV, 16'd0,     16'd1,     '{16'd0,  5'sd0}},
		'{ROW_REG,   REG_GAIN_INT,   16'd0,     16'd1,     '{16'd0,  5'sd0}},
		// error threshold edges, then a sum that truncates to no step
		'{ROW_TICK,  REG_GAIN_PROP,  16'd51,    16'd0,     '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd50,    16'd0,     '{16'd0,  5'sd0}},
		'{ROW_TICK,  REG_GAIN_PROP,  16'd1,     16'd0,     '{16'd0,  5'sd0}}
	};

	incremental_pid_pwm_speed_loop u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.target_speed   (target_speed),
		.measured_speed (measured_speed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pwm_width      (pwm_width),
		.width_step     (width_step),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_loop_model();
		gain_p     = '0;
		gain_i     = '0;
		gain_d     = '0;
		period_reg = PERIOD_RESET;
		err_hist   = 0;
		delta_hist = 0;
		width_hist = '0;
	endfunction

	function automatic void apply_reg(input ipps_reg_t sel, input logic [GAIN_W-1:0] val);
		case (sel)
			REG_GAIN_PROP:  gain_p     = val;
			REG_GAIN_INT:   gain_i     = val;
			REG_GAIN_DERIV: gain_d     = val;
			REG_PWM_PERIOD: period_reg = val;
			default: ;
		endcase
	endfunction

	// one control tick: error, differences, capped step, clamped width
	function automatic tick_result_t advance_speed_loop(input logic [SPEED_W-1:0] tgt,
			input logic [SPEED_W-1:0] meas);
		longint       e, d, dd, sum, mag, lim, stp, w, ceil_w;
		tick_result_t r;
		e   = longint'(tgt) - longint'(meas);
		d   = e - err_hist;
		dd  = d - delta_hist;
		sum = longint'(gain_p) * d + longint'(gain_i) * e + longint'(gain_d) * dd;
		lim = (e > longint'(HIGH_ERR_THRESH)) ? longint'(STEP_LIMIT_HIGH)
			: longint'(STEP_LIMIT_LOW);
		mag = (sum < 0) ? -sum : sum;
		if (mag > lim)
			mag = lim;
		stp = mag / STEP_DIV;
		if (sum < 0)
			stp = -stp;
		w      = longint'(width_hist) + stp;
		ceil_w = longint'(period_reg) - longint'(PERIOD_MARGIN);
		if (ceil_w < 0)
			ceil_w = 0;
		if (w < 0)
			w = 0;
		else if (w >= ceil_w) begin
			w = ceil_w;
			n_ceil_hits++;
		end
		err_hist   = e;
		delta_hist = d;
		width_hist = w[WIDTH_W-1:0];
		r.width    = width_hist;
		r.step     = stp[STEP_W-1:0];
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(3))
			0:       return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
			1:       return 16'($urandom_range(5));
			2:       return 16'($urandom_range(300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_period();
		case ($urandom_range(5))
			0:       return 16'($urandom_range(202));
			1:       return 16'($urandom_range(260, 201));
			2:       return PERIOD_RESET;
			3:       return 16'hFFFF;
			default: return 16'($urandom_range(65535, 201));
		endcase
	endfunction

	// Start and end on a rising edge; valid stays up unless a gap is taken.
	task automatic push_tick(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] meas,
			input bit known, input tick_result_t typed);
		tick_result_t pred;
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_valid       <= 1'b1;
		target_speed   <= tgt;
		measured_speed <= meas;
		do @(negedge clk); while (!in_ready);
		pred = advance_speed_loop(tgt, meas);
		expected_q.push_back(known ? typed : pred);
		n_ticks++;
		@(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input ipps_reg_t sel, input logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		apply_reg(sel, val);
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic drain_loop();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
	end

	// sample between edges so the handshake seen here is the one at the next edge
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_words++;
			if (expected_q.size() == 0) begin
				$error("unexpected word: pwm_width=%0d width_step=%0d", pwm_width, width_step);
				n_errors++;
			end else begin
				oldest_r = expected_q.pop_front();
				if (pwm_width !== oldest_r.width) begin
					$error("pwm_width: expected %0d, got %0d", oldest_r.width, pwm_width);
					n_errors++;
				end
				if (width_step !== oldest_r.step) begin
					$error("width_step: expected %0d, got %0d", oldest_r.step, width_step);
					n_errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		bit                 cfg_open;
		logic [SPEED_W-1:0] tgt;
		logic [SPEED_W-1:0] meas;
		int                 off;
		int                 mv;
		cfg_open = 1'b0;
		reset_loop_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_N; i++) begin
			if (plan[i].kind == ROW_REG) begin
				if (!cfg_open)
					drain_loop();
				write_reg(plan[i].sel, plan[i].b);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				push_tick(plan[i].a, plan[i].b, plan[i].kind == ROW_KNOWN, plan[i].want);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_loop();
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
				default: begin src_idle_pct = 20; snk_stall_pct = 20; end
			endcase
			if (ph == 0) begin
				write_reg(REG_GAIN_PROP, 16'hFFFF);
				write_reg(REG_GAIN_INT, 16'hFFFF);
				write_reg(REG_GAIN_DERIV, 16'hFFFF);
				write_reg(REG_PWM_PERIOD, 16'd201);
			end else begin
				write_reg(REG_GAIN_PROP, pick_gain());
				write_reg(REG_GAIN_INT, pick_gain());
				write_reg(REG_GAIN_DERIV, pick_gain());
				write_reg(REG_PWM_PERIOD, pick_period());
			end
			cfg_valid <= 1'b0;
			for (int k = 0; k < TICKS_PER_PH; k++) begin
				tgt = 16'($urandom);
				case ($urandom_range(9))
					0, 1, 2, 3: meas = 16'($urandom);
					4, 5, 6, 7: begin
						// hover near the setpoint, across the high-error threshold
						off = $urandom_range(160);
						mv  = int'(tgt) + off - 80;
						if (mv < 0)
							mv = 0;
						else if (mv > 65535)
							mv = 65535;
						meas = 16'(mv);
					end
					default: begin
						tgt  = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
						meas = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
					end
				endcase
				push_tick(tgt, meas, 1'b0, '0);
			end
		end

		drain_loop();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d expected words never arrived", expected_q.size());
			n_errors++;
		end
		$display("Ran %0d control ticks and checked %0d width words, %0d hit the ceiling.",
			n_ticks, n_words, n_ceil_hits);
		$display("Applied %0d register writes over %0d gain/period settings and four idle modes.",
			n_cfg, N_PHASES + 1);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
